FILE: sv/fsfq_pkg.sv
package fsfq_pkg;

   // Storage depth default
   localparam int DEPTH_DEFAULT = 16;

   // Configuration port
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 1'd1;

   localparam logic       POLICY_FIFO     = 1'b0;
   localparam logic       POLICY_SMALLEST = 1'b1;
   localparam logic [4:0] CAPACITY_RESET  = 5'd16;
   localparam logic [4:0] CAPACITY_MAX    = 5'd31;

   // Request operations
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_PUSHED = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_POPPED = 2'd2;
   localparam logic [1:0] STATUS_EMPTY  = 2'd3;

   // Per-cell commands
   typedef logic [1:0] cell_cmd_type;
   localparam cell_cmd_type CELL_HOLD      = 2'd0;
   localparam cell_cmd_type CELL_LOAD_NEW  = 2'd1;
   localparam cell_cmd_type CELL_TAKE_PREV = 2'd2;
   localparam cell_cmd_type CELL_TAKE_NEXT = 2'd3;

   typedef struct packed {
      logic [15:0] conn_id;
      logic [15:0] name_tag;
      logic [31:0] size_bytes;
   } entry_type;

   typedef struct packed {
      logic        op;
      logic [15:0] conn_id;
      logic [15:0] name_tag;
      logic [31:0] size_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_conn_id;
      logic [15:0] out_name_tag;
      logic [31:0] out_size_bytes;
      logic [4:0]  occupancy;
   } rsp_type;

endpackage

FILE: sv/fsfq_cell.sv
module fsfq_cell (
   input  logic                   clock,
   input  fsfq_pkg::cell_cmd_type cmd,
   input  fsfq_pkg::entry_type    prev_entry,
   input  fsfq_pkg::entry_type    next_entry,
   input  fsfq_pkg::entry_type    new_entry,
   output fsfq_pkg::entry_type    entry_q,
   output logic                   key_lt,
   output logic                   key_le
);
   import fsfq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Pick the next content: hold, take the new request or a neighbor's entry
   always_comb begin
      case (cmd)
         CELL_HOLD:      entry_in = entry_ff;
         CELL_LOAD_NEW:  entry_in = new_entry;
         CELL_TAKE_PREV: entry_in = prev_entry;
         CELL_TAKE_NEXT: entry_in = next_entry;
         default:        entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Compare the broadcast key against the held size
   assign key_lt  = new_entry.size_bytes <  entry_ff.size_bytes;
   assign key_le  = new_entry.size_bytes <= entry_ff.size_bytes;
   assign entry_q = entry_ff;

endmodule

FILE: sv/fifo_or_smallest_first_request_queue.sv
// Channel   Direction  Payload              Handshake
// req       in         fsfq_pkg::req_type   req_valid / req_stall
// rsp       out        fsfq_pkg::rsp_type   rsp_valid / rsp_stall
// csr       in         policy, capacity     csr_write / csr_index / csr_data
//
// A pop, a rejected push, a first-in first-out push and a push into an empty
// queue finish in the cycle they are accepted. A smallest-first push walks a
// cursor down the row of cells, one cell per cycle, until it reaches the position
// it lands at. Results leave through an output register; the next beat is taken
// once the previous result has moved there. Reset is synchronous and empties the
// queue; no clearing pass is needed.
module fifo_or_smallest_first_request_queue #(
   parameter int DEPTH = fsfq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [fsfq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsfq_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fsfq_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fsfq_pkg::rsp_type                   rsp_data
);
   import fsfq_pkg::*;

   // Occupancy never exceeds the 5-bit capacity limit
   localparam int LIMIT_MAX_I = (DEPTH < 31) ? DEPTH : 31;
   localparam logic [4:0] LIMIT_MAX = 5'(LIMIT_MAX_I);
   localparam int CW = $clog2(LIMIT_MAX_I + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             policy_ff;
   logic [4:0]       capacity_ff;
   entry_type        new_ff, new_in;
   logic [DEPTH-1:0] before_ff, before_in;
   rsp_type          pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   entry_type        req_entry;
   entry_type        key_entry;
   entry_type        cell_q [DEPTH];
   cell_cmd_type     cell_cmd [DEPTH];
   logic [DEPTH-1:0] key_lt;
   logic [DEPTH-1:0] key_le;
   logic [DEPTH-1:0] at_cur;
   logic [DEPTH-1:0] hit_cur;
   logic [4:0]       limit;
   logic             full;
   logic             out_free;
   logic             accept;
   logic             walk_hit;

   assign req_entry = '{conn_id:    req_data.conn_id,
                        name_tag:   req_data.name_tag,
                        size_bytes: req_data.size_bytes};
   assign key_entry = (state_ff == ST_WALK) ? new_ff : req_entry;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Effective limit is the smaller of capacity and storage depth
   assign limit = (capacity_ff < LIMIT_MAX) ? capacity_ff : LIMIT_MAX;
   assign full  = (5'(count_ff) >= limit);

   // Build the row of cells and the cursor test at each one
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign at_cur[i]  = !before_ff[i];
         assign hit_cur[i] = (count_ff == '0) || key_lt[i];
         fsfq_cell u_cell (
            .clock      (clock),
            .cmd        (cell_cmd[i]),
            .prev_entry (key_entry),
            .next_entry (cell_q[(DEPTH > 1) ? 1 : 0]),
            .new_entry  (key_entry),
            .entry_q    (cell_q[i]),
            .key_lt     (key_lt[i]),
            .key_le     (key_le[i])
         );
      end else if (i == DEPTH - 1) begin : g_tail
         assign at_cur[i]  = !before_ff[i] && before_ff[i-1];
         assign hit_cur[i] = (32'(count_ff) <= 32'(i)) || key_le[i];
         fsfq_cell u_cell (
            .clock      (clock),
            .cmd        (cell_cmd[i]),
            .prev_entry (cell_q[i-1]),
            .next_entry (key_entry),
            .new_entry  (key_entry),
            .entry_q    (cell_q[i]),
            .key_lt     (key_lt[i]),
            .key_le     (key_le[i])
         );
      end else begin : g_body
         assign at_cur[i]  = !before_ff[i] && before_ff[i-1];
         assign hit_cur[i] = (32'(count_ff) <= 32'(i)) || key_le[i];
         fsfq_cell u_cell (
            .clock      (clock),
            .cmd        (cell_cmd[i]),
            .prev_entry (cell_q[i-1]),
            .next_entry (cell_q[i+1]),
            .new_entry  (key_entry),
            .entry_q    (cell_q[i]),
            .key_lt     (key_lt[i]),
            .key_le     (key_le[i])
         );
      end
   end

   assign walk_hit = |(at_cur & hit_cur);

   // Sequence the operation and steer the cells
   always_comb begin
      logic    done;
      rsp_type res;
      done      = 1'b0;
      res       = '0;
      state_in  = state_ff;
      count_in  = count_ff;
      new_in    = new_ff;
      before_in = before_ff;
      pend_in   = pend_ff;
      rsp_in    = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      for (int i = 0; i < DEPTH; i++) begin
         cell_cmd[i] = CELL_HOLD;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_POP) begin
                  done = 1'b1;
                  if (count_ff == '0) begin
                     res.status = STATUS_EMPTY;
                  end else begin
                     res.status         = STATUS_POPPED;
                     res.out_conn_id    = cell_q[0].conn_id;
                     res.out_name_tag   = cell_q[0].name_tag;
                     res.out_size_bytes = cell_q[0].size_bytes;
                     count_in           = count_ff - CW'(1);
                     for (int i = 0; i < DEPTH; i++) begin
                        cell_cmd[i] = CELL_TAKE_NEXT;
                     end
                  end
               end else if (full) begin
                  done       = 1'b1;
                  res.status = STATUS_FULL;
               end else if (policy_ff == POLICY_FIFO || count_ff == '0) begin
                  // Append at the tail
                  done       = 1'b1;
                  res.status = STATUS_PUSHED;
                  count_in   = count_ff + CW'(1);
                  for (int i = 0; i < DEPTH; i++) begin
                     if (32'(count_ff) == 32'(i)) begin
                        cell_cmd[i] = CELL_LOAD_NEW;
                     end
                  end
               end else begin
                  // Start the cursor at the head
                  new_in    = req_entry;
                  before_in = '0;
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (walk_hit) begin
               // Insert at the cursor, shift the rest down
               done       = 1'b1;
               res.status = STATUS_PUSHED;
               count_in   = count_ff + CW'(1);
               for (int i = 0; i < DEPTH; i++) begin
                  if (at_cur[i]) begin
                     cell_cmd[i] = CELL_LOAD_NEW;
                  end else if (!before_ff[i]) begin
                     cell_cmd[i] = CELL_TAKE_PREV;
                  end
               end
            end else begin
               before_in = before_ff | at_cur;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Deliver the result now or park it until the output frees up
      if (done) begin
         res.occupancy = 5'(count_in);
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = res;
            state_in = ST_EMIT;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         policy_ff    <= POLICY_FIFO;
         capacity_ff  <= CAPACITY_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_POLICY:   policy_ff   <= csr_data[0];
               CSR_CAPACITY: capacity_ff <= csr_data;
               default:      policy_ff   <= policy_ff;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      new_ff    <= new_in;
      before_ff <= before_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import fsfq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
   localparam int PHASES      = 12;
   localparam int PHASE_BEATS = 120;

   typedef enum logic {ROW_CSR, ROW_BEAT} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  val;
      req_type                beat;
      bit                     typed;
      rsp_type                want;
   } step_row_type;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;

   // Mirror of the queue contents and the two registers
   entry_type   held[$];
   logic        cfg_policy   = POLICY_FIFO;
   logic [4:0]  cfg_capacity = CAPACITY_RESET;

   rsp_type      pending_rsp[$];
   step_row_type plan[$];
   int unsigned  faults    = 0;
   int unsigned  rsp_wait  = 0;
   bit           req_quiet = 1'b0;
   bit           rsp_quiet = 1'b0;

   fifo_or_smallest_first_request_queue dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #(5_000_000);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int unsigned draw_wait(bit quiet);
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   // Apply one request to the mirrored queue and return the response it earns
   function automatic rsp_type next_response(req_type r);
      rsp_type     o;
      entry_type   e;
      int unsigned lim;
      int unsigned pos;
      o = '0;
      if (r.op == OP_PUSH) begin
         lim = (cfg_capacity < QUEUE_DEPTH) ? cfg_capacity : QUEUE_DEPTH;
         if (held.size() >= lim) begin
            o.status = STATUS_FULL;
         end else begin
            e.conn_id    = r.conn_id;
            e.name_tag   = r.name_tag;
            e.size_bytes = r.size_bytes;
            if (cfg_policy == POLICY_FIFO) begin
               pos = held.size();
            end else if (held.size() == 0 || r.size_bytes < held[0].size_bytes) begin
               pos = 0;
            end else begin
               // walk past the head to the first entry at least as large
               pos = 1;
               while (pos < held.size() && r.size_bytes > held[pos].size_bytes)
                  pos++;
            end
            held.insert(pos, e);
            o.status = STATUS_PUSHED;
         end
      end else if (held.size() == 0) begin
         o.status = STATUS_EMPTY;
      end else begin
         e = held.pop_front();
         o.status         = STATUS_POPPED;
         o.out_conn_id    = e.conn_id;
         o.out_name_tag   = e.name_tag;
         o.out_size_bytes = e.size_bytes;
      end
      o.occupancy = 5'(held.size());
      return o;
   endfunction

   function automatic step_row_type csr_row(logic [CSR_INDEX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] val);
      step_row_type s;
      s.kind  = ROW_CSR;
      s.idx   = idx;
      s.val   = val;
      s.beat  = '0;
      s.typed = 1'b0;
      s.want  = '0;
      return s;
   endfunction

   function automatic step_row_type beat_row(logic op, logic [15:0] conn, logic [15:0] tag,
                                             logic [31:0] size);
      step_row_type s;
      s.kind  = ROW_BEAT;
      s.idx   = '0;
      s.val   = '0;
      s.beat  = req_type'({op, conn, tag, size});
      s.typed = 1'b0;
      s.want  = '0;
      return s;
   endfunction

   function automatic step_row_type typed_row(logic op, logic [15:0] conn, logic [15:0] tag,
                                              logic [31:0] size, logic [1:0] st,
                                              logic [15:0] oc, logic [15:0] ot,
                                              logic [31:0] os, logic [4:0] occ);
      step_row_type s;
      s       = beat_row(op, conn, tag, size);
      s.typed = 1'b1;
      s.want  = rsp_type'({st, oc, ot, os, occ});
      return s;
   endfunction

   // Write one register; the block must be idle
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      if (idx == CSR_POLICY)
         cfg_policy = val[0];
      else
         cfg_capacity = val;
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and wait until every response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Offer one beat after a random gap and hold it until taken
   task automatic send_beat(req_type r, bit typed, rsp_type want);
      int unsigned gap;
      rsp_type     pred;
      gap = draw_wait(req_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (req_stall);
      pred = next_response(r);
      pending_rsp.push_back(typed ? want : pred);
   endtask

   // Response side back-pressure: a fresh wait after each taken beat
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         rsp_wait = draw_wait(rsp_quiet);
      else if (rsp_wait != 0)
         rsp_wait = rsp_wait - 1;
      rsp_stall <= (rsp_wait != 0);
   end

   // Compare each taken response with the oldest expectation
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected response: status %0d conn %h tag %h size %h occ %0d",
                        rsp_data.status, rsp_data.out_conn_id, rsp_data.out_name_tag,
                        rsp_data.out_size_bytes, rsp_data.occupancy);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.out_conn_id !== want.out_conn_id ||
                rsp_data.out_name_tag !== want.out_name_tag ||
                rsp_data.out_size_bytes !== want.out_size_bytes ||
                rsp_data.occupancy !== want.occupancy) begin
               faults++;
               if (faults <= 10) begin
                  $display("mismatch at %0t", $realtime);
                  $display("  expected: status %0d conn %h tag %h size %h occ %0d",
                           want.status, want.out_conn_id, want.out_name_tag,
                           want.out_size_bytes, want.occupancy);
                  $display("  actual:   status %0d conn %h tag %h size %h occ %0d",
                           rsp_data.status, rsp_data.out_conn_id, rsp_data.out_name_tag,
                           rsp_data.out_size_bytes, rsp_data.occupancy);
               end
            end
         end
      end
   end

   initial begin : stimulus
      req_type     r;
      int unsigned push_pct;
      logic [4:0]  cap;
      logic        pol;

      // Directed rows, reset state first
      plan.push_back(typed_row(OP_POP, 16'h1234, 16'h5678, 32'h9abc_def0,
                               STATUS_EMPTY, 16'h0, 16'h0, 32'h0, 5'd0));
      plan.push_back(typed_row(OP_PUSH, 16'hffff, 16'hffff, 32'hffff_ffff,
                               STATUS_PUSHED, 16'h0, 16'h0, 32'h0, 5'd1));
      plan.push_back(typed_row(OP_PUSH, 16'h0, 16'h0, 32'h0,
                               STATUS_PUSHED, 16'h0, 16'h0, 32'h0, 5'd2));
      plan.push_back(typed_row(OP_POP, 16'h0, 16'h0, 32'h0,
                               STATUS_POPPED, 16'hffff, 16'hffff, 32'hffff_ffff, 5'd1));
      plan.push_back(typed_row(OP_POP, 16'hffff, 16'hffff, 32'hffff_ffff,
                               STATUS_POPPED, 16'h0, 16'h0, 32'h0, 5'd0));
      // zero capacity rejects every push
      plan.push_back(csr_row(CSR_CAPACITY, 5'd0));
      plan.push_back(typed_row(OP_PUSH, 16'h00a5, 16'h005a, 32'd7,
                               STATUS_FULL, 16'h0, 16'h0, 32'h0, 5'd0));
      // single slot
      plan.push_back(csr_row(CSR_CAPACITY, 5'd1));
      plan.push_back(typed_row(OP_PUSH, 16'h0001, 16'h0101, 32'd5,
                               STATUS_PUSHED, 16'h0, 16'h0, 32'h0, 5'd1));
      plan.push_back(typed_row(OP_PUSH, 16'h0002, 16'h0202, 32'd1,
                               STATUS_FULL, 16'h0, 16'h0, 32'h0, 5'd1));
      // smallest-first with an entry still held, capacity above depth
      plan.push_back(csr_row(CSR_POLICY, 5'(POLICY_SMALLEST)));
      plan.push_back(csr_row(CSR_CAPACITY, CAPACITY_MAX));
      plan.push_back(beat_row(OP_PUSH, 16'h0003, 16'h0303, 32'd10));
      plan.push_back(beat_row(OP_PUSH, 16'h0004, 16'h0404, 32'd3));
      // equal to the head: lands right after it
      plan.push_back(beat_row(OP_PUSH, 16'h0005, 16'h0505, 32'd3));
      // equal to a later entry: lands before it
      plan.push_back(beat_row(OP_PUSH, 16'h0006, 16'h0606, 32'd10));
      plan.push_back(beat_row(OP_PUSH, 16'h0007, 16'h0707, 32'hffff_ffff));
      plan.push_back(beat_row(OP_PUSH, 16'h0008, 16'h0808, 32'd0));
      repeat (7)
         plan.push_back(beat_row(OP_POP, 16'h0, 16'h0, 32'h0));
      plan.push_back(typed_row(OP_POP, 16'h0, 16'h0, 32'h0,
                               STATUS_EMPTY, 16'h0, 16'h0, 32'h0, 5'd0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_drained();
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            send_beat(plan[i].beat, plan[i].typed, plan[i].want);
         end
      end

      // Random phases; queue contents carry over across register changes
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         pol = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
         case (ph % 4)
            0:       cap = CAPACITY_RESET;
            1:       cap = CAPACITY_MAX;
            2:       cap = 5'($urandom_range(1, 15));
            default: cap = 5'($urandom_range(0, 31));
         endcase
         write_reg(CSR_POLICY, 5'(pol));
         write_reg(CSR_CAPACITY, cap);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // alternate fill and drain stretches to reach full and empty
            push_pct     = ((n / 24) % 2 == 0) ? 75 : 30;
            r.op         = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            r.conn_id    = 16'($urandom);
            r.name_tag   = 16'($urandom);
            r.size_bytes = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 7))
                                                       : 32'($urandom);
            send_beat(r, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (faults == 0 && pending_rsp.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
